@@ rtl/amc_pkg.sv @@
`default_nettype none

package amc_pkg;

  // fixed field widths
  localparam int unsigned MAG_W      = 12;
  localparam int unsigned ALPHA_W    = 9;
  localparam int unsigned SENS_W     = 16;
  localparam int unsigned SCALE_W    = 8;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned DVD_W      = MAG_W + SCALE_W;

  // fixed constants
  localparam logic [MAG_W-1:0]   MAG_MAX   = 12'd4095;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;
  localparam logic [SCALE_W-1:0] SCALE_MAX = 8'd255;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SENSITIVITY   = 3'd0,
    CFG_CALIBRATION   = 3'd1,
    CFG_SLEEP_THRESH  = 3'd2,
    CFG_EMA_ALPHA     = 3'd3,
    CFG_DEADBAND      = 3'd4,
    CFG_SLEEP_WAIT    = 3'd5,
    CFG_BYPASS        = 3'd6
  } cfg_idx_e;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT_GO,
    ST_ROOT_WAIT,
    ST_HI,
    ST_LO,
    ST_EMA,
    ST_UPDATE,
    ST_DEV,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_FINISH
  } state_e;

  // operand source for the shared multiplier
  typedef enum logic [2:0] {
    MS_NONE,
    MS_AXIS,
    MS_HI,
    MS_LO,
    MS_EMA,
    MS_DEV
  } mul_sel_e;

  // sequencer controls to the datapath
  typedef struct packed {
    mul_sel_e mul_sel;
    logic     take;
    logic     sum_first;
    logic     sum_add;
    logic     sqrt_start;
    logic     root_take;
    logic     hi_take;
    logic     lo_take;
    logic     update_en;
    logic     div_start;
    logic     out_load;
  } ctl_t;

endpackage

`default_nettype wire

@@ rtl/accel_magnitude_conditioner.sv @@
// channel  | handshake                    | payload
// ---------+------------------------------+---------------------------------------------
// sample   | in_valid_i / in_stall_o      | x_word_i y_word_i z_word_i now_ms_i
// result   | out_valid_o / out_stall_i    | accepted_o changed_o raw_magnitude_o
//          |                              | smooth_magnitude_o intensity_o sleeping_o
// config   | cfg_we_i                     | cfg_index_i cfg_data_i
//
// One request at a time: a repeated sample skips the bound and smoothing states, a saturated
// intensity skips the divider iterations; the bit-serial square root and the eight-step
// divider do most of the work, around one shared multiplier.
// in_stall_o is high from accept until the result is loaded into the output register.
// A finished result waits there under out_stall_i; the next sample is taken meanwhile.
// Reset (rst_ni low, asynchronous) restores control, config and history state and unprimes.
`default_nettype none

module accel_magnitude_conditioner #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [15:0]                        x_word_i,
  input  wire logic [15:0]                        y_word_i,
  input  wire logic [15:0]                        z_word_i,
  input  wire logic [amc_pkg::TIME_W-1:0]         now_ms_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic                                    accepted_o,
  output logic                                    changed_o,
  output logic      [amc_pkg::MAG_W-1:0]          raw_magnitude_o,
  output logic      [amc_pkg::MAG_W-1:0]          smooth_magnitude_o,
  output logic      [amc_pkg::SCALE_W-1:0]        intensity_o,
  output logic                                    sleeping_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [amc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [amc_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned SB    = SAMPLE_BITS;
  localparam int unsigned MW    = (SB > 13) ? SB : 13;
  localparam int unsigned PW    = 2 * MW;
  localparam int unsigned RAD_W = 2 * SB;
  localparam int unsigned RXW   = SB + amc_pkg::MAG_W;
  localparam int unsigned MG    = amc_pkg::MAG_W;
  localparam int unsigned TW    = amc_pkg::TIME_W;
  localparam int unsigned AW    = amc_pkg::ALPHA_W;
  localparam int unsigned QW    = amc_pkg::SCALE_W;

  // absolute value of a signed sample, fits SB bits unsigned
  function automatic logic [SB-1:0] abs_sample(input logic [SB-1:0] v);
    abs_sample = v[SB-1] ? (~v + SB'(1)) : v;
  endfunction

  amc_pkg::state_e state_q, state_d;
  amc_pkg::ctl_t   ctl;

  // configuration registers
  logic [amc_pkg::SENS_W-1:0] sens_q;
  logic [MG-1:0]              cal_q;
  logic [MG-1:0]              thr_q;
  logic [AW-1:0]              alpha_cfg_q;
  logic [MG-1:0]              deadband_q;
  logic [TW-1:0]              wait_q;
  logic                       bypass_q;

  // persistent state
  logic          primed_q;
  logic [SB-1:0] last_x_q, last_y_q, last_z_q;
  logic [MG-1:0] smooth_q;
  logic [TW-1:0] last_move_q;
  logic [1:0]    ax_cnt_q;
  logic          out_valid_q;

  // per-request working registers
  logic [SB-1:0] x_q, y_q, z_q;
  logic [TW-1:0] now_q;
  logic          acc_q;
  logic [PW-1:0] sum_q;
  logic [MG-1:0] mag_q;
  logic          move_q;
  logic          chg_q;

  // output register
  logic          res_acc_q;
  logic          res_chg_q;
  logic [MG-1:0] res_raw_q;
  logic [MG-1:0] res_smooth_q;
  logic [QW-1:0] res_int_q;
  logic          res_sleep_q;

  // datapath signals
  logic [SB-1:0] x_new, y_new, z_new;
  logic [SB-1:0] ax_sel;
  logic [MW-1:0] mul_a, mul_b;
  logic [PW-1:0] mul_p;
  logic          root_done;
  logic [SB-1:0] root;
  logic [RXW-1:0] root_ext;
  logic [MG-1:0] mag_sat;
  logic          div_done;
  logic [QW-1:0] quotient;
  logic [MG:0]   hi;
  logic [MG-1:0] lo;
  logic          lo_ok;
  logic [AW-1:0] alpha;
  logic          ema_neg;
  logic [MG-1:0] ema_dabs;
  logic [MG-1:0] step_fl;
  logic [MG-1:0] step_ce;
  logic [MG-1:0] smooth_new;
  logic [MG-1:0] chg_abs;
  logic [MG-1:0] dev;
  logic [amc_pkg::SENS_W-1:0] divisor;
  logic          sleep_now;
  logic          out_free;

  // sample fields sit in the top bits of each word
  assign x_new = x_word_i[15 -: SB];
  assign y_new = y_word_i[15 -: SB];
  assign z_new = z_word_i[15 -: SB];

  assign in_stall_o = (state_q != amc_pkg::ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      amc_pkg::ST_IDLE:      if (in_valid_i) state_d = amc_pkg::ST_SQUARE;
      amc_pkg::ST_SQUARE:    if (ax_cnt_q == 2'd3) state_d = amc_pkg::ST_ROOT_GO;
      amc_pkg::ST_ROOT_GO:   state_d = amc_pkg::ST_ROOT_WAIT;
      amc_pkg::ST_ROOT_WAIT: begin
        if (root_done) state_d = acc_q ? amc_pkg::ST_HI : amc_pkg::ST_DEV;
      end
      amc_pkg::ST_HI:        state_d = amc_pkg::ST_LO;
      amc_pkg::ST_LO:        state_d = amc_pkg::ST_EMA;
      amc_pkg::ST_EMA:       state_d = amc_pkg::ST_UPDATE;
      amc_pkg::ST_UPDATE:    state_d = amc_pkg::ST_DEV;
      amc_pkg::ST_DEV:       state_d = amc_pkg::ST_DIV_GO;
      amc_pkg::ST_DIV_GO:    state_d = amc_pkg::ST_DIV_WAIT;
      amc_pkg::ST_DIV_WAIT:  if (div_done) state_d = amc_pkg::ST_FINISH;
      amc_pkg::ST_FINISH:    if (out_free) state_d = amc_pkg::ST_IDLE;
      default:               state_d = amc_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    ctl = '0;
    ctl.mul_sel = amc_pkg::MS_NONE;
    unique case (state_q)
      amc_pkg::ST_IDLE:      ctl.take = in_valid_i;
      amc_pkg::ST_SQUARE: begin
        ctl.mul_sel   = amc_pkg::MS_AXIS;
        ctl.sum_first = (ax_cnt_q == 2'd1);
        ctl.sum_add   = (ax_cnt_q == 2'd2) || (ax_cnt_q == 2'd3);
      end
      amc_pkg::ST_ROOT_GO:   ctl.sqrt_start = 1'b1;
      amc_pkg::ST_ROOT_WAIT: ctl.root_take = root_done;
      amc_pkg::ST_HI:        ctl.mul_sel = amc_pkg::MS_HI;
      amc_pkg::ST_LO: begin
        ctl.mul_sel = amc_pkg::MS_LO;
        ctl.hi_take = 1'b1;
      end
      amc_pkg::ST_EMA: begin
        ctl.mul_sel = amc_pkg::MS_EMA;
        ctl.lo_take = 1'b1;
      end
      amc_pkg::ST_UPDATE:    ctl.update_en = 1'b1;
      amc_pkg::ST_DEV:       ctl.mul_sel = amc_pkg::MS_DEV;
      amc_pkg::ST_DIV_GO:    ctl.div_start = 1'b1;
      amc_pkg::ST_DIV_WAIT:  ctl.take = 1'b0;
      amc_pkg::ST_FINISH:    ctl.out_load = out_free;
      default:               ctl.take = 1'b0;
    endcase
  end

  // bounds, smoothing and deviation terms
  always_comb begin
    hi       = {1'b0, cal_q} + {1'b0, thr_q};
    lo       = cal_q - thr_q;
    lo_ok    = cal_q > thr_q;
    alpha    = (alpha_cfg_q > amc_pkg::ALPHA_ONE) ? amc_pkg::ALPHA_ONE : alpha_cfg_q;
    ema_neg  = mag_q < smooth_q;
    ema_dabs = ema_neg ? (smooth_q - mag_q) : (mag_q - smooth_q);
    step_fl  = mul_p[MG+QW-1:QW];
    step_ce  = step_fl + MG'(|mul_p[QW-1:0]);
    smooth_new = ema_neg ? (smooth_q - step_ce) : (smooth_q + step_fl);
    chg_abs  = (smooth_new >= smooth_q) ? (smooth_new - smooth_q) : (smooth_q - smooth_new);
    dev      = (smooth_q > cal_q) ? (smooth_q - cal_q) : (cal_q - smooth_q);
    divisor  = (sens_q == '0) ? amc_pkg::SENS_W'(1) : sens_q;
    root_ext = RXW'(root);
    mag_sat  = (root_ext > RXW'(amc_pkg::MAG_MAX)) ? amc_pkg::MAG_MAX : root_ext[MG-1:0];
    sleep_now = (now_q - last_move_q) >= wait_q;
  end

  // shared multiplier operand select
  always_comb begin
    unique case (ax_cnt_q)
      2'd0:    ax_sel = abs_sample(x_q);
      2'd1:    ax_sel = abs_sample(y_q);
      default: ax_sel = abs_sample(z_q);
    endcase
    mul_a = '0;
    mul_b = '0;
    unique case (ctl.mul_sel)
      amc_pkg::MS_AXIS: begin
        mul_a = MW'(ax_sel);
        mul_b = MW'(ax_sel);
      end
      amc_pkg::MS_HI: begin
        mul_a = MW'(hi);
        mul_b = MW'(hi);
      end
      amc_pkg::MS_LO: begin
        mul_a = MW'(lo);
        mul_b = MW'(lo);
      end
      amc_pkg::MS_EMA: begin
        mul_a = MW'(ema_dabs);
        mul_b = MW'(alpha);
      end
      amc_pkg::MS_DEV: begin
        mul_a = MW'(dev);
        mul_b = MW'(amc_pkg::SCALE_MAX);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  amc_mul #(
    .WIDTH (MW)
  ) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  amc_isqrt #(
    .SAMPLE_BITS (SB)
  ) u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctl.sqrt_start),
    .radicand_i (sum_q[RAD_W-1:0]),
    .done_o     (root_done),
    .root_o     (root)
  );

  amc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctl.div_start),
    .dividend_i (mul_p[amc_pkg::DVD_W-1:0]),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // state register and sequencer counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= amc_pkg::ST_IDLE;
      ax_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (ctl.take) begin
        ax_cnt_q <= '0;
      end else if (state_q == amc_pkg::ST_SQUARE) begin
        ax_cnt_q <= ax_cnt_q + 2'd1;
      end
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sens_q      <= 16'd256;
      cal_q       <= '0;
      thr_q       <= 12'd10;
      alpha_cfg_q <= 9'd64;
      deadband_q  <= 12'd2;
      wait_q      <= 32'd60000;
      bypass_q    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (amc_pkg::cfg_idx_e'(cfg_index_i))
        amc_pkg::CFG_SENSITIVITY:  sens_q      <= cfg_data_i[amc_pkg::SENS_W-1:0];
        amc_pkg::CFG_CALIBRATION:  cal_q       <= cfg_data_i[MG-1:0];
        amc_pkg::CFG_SLEEP_THRESH: thr_q       <= cfg_data_i[MG-1:0];
        amc_pkg::CFG_EMA_ALPHA:    alpha_cfg_q <= cfg_data_i[AW-1:0];
        amc_pkg::CFG_DEADBAND:     deadband_q  <= cfg_data_i[MG-1:0];
        amc_pkg::CFG_SLEEP_WAIT:   wait_q      <= cfg_data_i[TW-1:0];
        amc_pkg::CFG_BYPASS:       bypass_q    <= cfg_data_i[0];
        default:                   bypass_q    <= bypass_q;
      endcase
    end
  end

  // persistent sample state, smoothing and movement time
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q    <= 1'b0;
      last_x_q    <= '0;
      last_y_q    <= '0;
      last_z_q    <= '0;
      smooth_q    <= '0;
      last_move_q <= '0;
    end else begin
      if (ctl.take && !primed_q) begin
        primed_q <= 1'b1;
        smooth_q <= cal_q;
      end
      if (ctl.update_en) begin
        last_x_q <= x_q;
        last_y_q <= y_q;
        last_z_q <= z_q;
        smooth_q <= smooth_new;
        if (move_q) begin
          last_move_q <= now_q;
        end
      end
    end
  end

  // working registers of the current request
  always_ff @(posedge clk_i) begin
    if (ctl.take) begin
      x_q   <= x_new;
      y_q   <= y_new;
      z_q   <= z_new;
      now_q <= now_ms_i;
      acc_q <= (x_new != last_x_q) || (y_new != last_y_q) || (z_new != last_z_q);
      chg_q <= 1'b0;
    end
    if (ctl.sum_first) begin
      sum_q <= mul_p;
    end else if (ctl.sum_add) begin
      sum_q <= sum_q + mul_p;
    end
    if (ctl.root_take) begin
      mag_q <= mag_sat;
    end
    if (ctl.hi_take) begin
      move_q <= sum_q > mul_p;
    end
    if (ctl.lo_take) begin
      move_q <= move_q || (lo_ok && (sum_q < mul_p));
    end
    if (ctl.update_en) begin
      chg_q <= bypass_q || (chg_abs >= deadband_q);
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (ctl.out_load) begin
      res_acc_q    <= acc_q;
      res_chg_q    <= chg_q;
      res_raw_q    <= mag_q;
      res_smooth_q <= smooth_q;
      res_int_q    <= quotient;
      res_sleep_q  <= sleep_now;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign accepted_o         = res_acc_q;
  assign changed_o          = res_chg_q;
  assign raw_magnitude_o    = res_raw_q;
  assign smooth_magnitude_o = res_smooth_q;
  assign intensity_o        = res_int_q;
  assign sleeping_o         = res_sleep_q;

endmodule

`default_nettype wire

@@ rtl/amc_mul.sv @@
`default_nettype none

module amc_mul #(
  parameter int unsigned WIDTH = 13
) (
  input  wire logic               clk_i,
  input  wire logic [WIDTH-1:0]   a_i,
  input  wire logic [WIDTH-1:0]   b_i,
  output logic      [2*WIDTH-1:0] p_o
);

  logic [2*WIDTH-1:0] p_q;

  // registered unsigned product
  always_ff @(posedge clk_i) begin
    p_q <= (2*WIDTH)'(a_i) * (2*WIDTH)'(b_i);
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

@@ rtl/amc_isqrt.sv @@
`default_nettype none

module amc_isqrt #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [2*SAMPLE_BITS-1:0]   radicand_i,
  output logic                            done_o,
  output logic      [SAMPLE_BITS-1:0]     root_o
);

  localparam int unsigned RAD_W = 2 * SAMPLE_BITS;
  localparam int unsigned REM_W = SAMPLE_BITS + 2;
  localparam int unsigned CNT_W = $clog2(SAMPLE_BITS + 1);

  logic                   busy_q;
  logic                   done_q;
  logic [CNT_W-1:0]       cnt_q;
  logic [RAD_W-1:0]       rad_q;
  logic [REM_W-1:0]       rem_q;
  logic [SAMPLE_BITS-1:0] root_q;
  logic [REM_W-1:0]       rem_sh;
  logic [REM_W-1:0]       trial;
  logic                   fit;

  // one result bit per cycle, two radicand bits brought down
  always_comb begin
    rem_sh = {rem_q[SAMPLE_BITS-1:0], rad_q[RAD_W-1 -: 2]};
    trial  = {root_q, 2'b01};
    fit    = rem_sh >= trial;
  end

  // iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(SAMPLE_BITS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // remainder and root
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
      rem_q  <= fit ? (rem_sh - trial) : rem_sh;
      root_q <= {root_q[SAMPLE_BITS-2:0], fit};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

@@ rtl/amc_div.sv @@
`default_nettype none

module amc_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [amc_pkg::DVD_W-1:0]   dividend_i,
  input  wire logic [amc_pkg::SENS_W-1:0]  divisor_i,
  output logic                             done_o,
  output logic      [amc_pkg::SCALE_W-1:0] quotient_o
);

  localparam int unsigned DW    = amc_pkg::DVD_W;
  localparam int unsigned SW    = amc_pkg::SENS_W;
  localparam int unsigned QW    = amc_pkg::SCALE_W;
  localparam int unsigned CW    = SW + QW;
  localparam int unsigned CNT_W = $clog2(QW + 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [SW-1:0]    rem_q;
  logic [QW-1:0]    low_q;
  logic [SW-1:0]    div_q;
  logic [QW-1:0]    quo_q;
  logic             sat;
  logic [SW:0]      sh;
  logic             fit;

  // quotient past the top of the scale saturates at once
  always_comb begin
    sat = CW'(dividend_i) >= {divisor_i, {QW{1'b0}}};
    sh  = {rem_q, low_q[QW-1]};
    fit = sh >= {1'b0, div_q};
  end

  // iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= (start_i && sat) || (busy_q && (cnt_q == CNT_W'(1)));
      if (start_i) begin
        busy_q <= !sat;
        cnt_q  <= CNT_W'(QW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // restoring long division, one quotient bit per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= SW'(dividend_i[DW-1:QW]);
      low_q <= dividend_i[QW-1:0];
      div_q <= divisor_i;
      quo_q <= sat ? amc_pkg::SCALE_MAX : '0;
    end else if (busy_q) begin
      rem_q <= fit ? SW'(sh - {1'b0, div_q}) : sh[SW-1:0];
      low_q <= {low_q[QW-2:0], 1'b0};
      quo_q <= {quo_q[QW-2:0], fit};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

@@ rtl/amc_checker.sv @@
`default_nettype none

module amc_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_stall_o,
  input wire logic                        out_valid_o,
  input wire logic                        out_stall_i,
  input wire logic                        accepted_o,
  input wire logic                        changed_o,
  input wire logic [amc_pkg::MAG_W-1:0]   raw_magnitude_o
);

  // a taken request keeps the block busy on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("block not busy after taking a request");

  // a result only appears at the end of work in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a request in progress");

  // a change is only reported for a processed sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (accepted_o || !changed_o))
    else $error("changed set on an ignored sample");

  // a stalled result stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(accepted_o) && $stable(raw_magnitude_o)))
    else $error("stalled result dropped or changed");

endmodule

bind accel_magnitude_conditioner amc_checker u_amc_checker (.*);

`default_nettype wire
